>>> design/lzss_decoder_4k_core_macros.svh
// assertion macros for the lzss 4k decoder core
// expects clk and rst to be visible in the module that expands them
`ifndef LZSS_DECODER_4K_CORE_MACROS_SVH
`define LZSS_DECODER_4K_CORE_MACROS_SVH

// same-cycle implication
`define LZ4K_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzss4k assertion failed");

// next-cycle implication
`define LZ4K_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzss4k assertion failed");

`endif

>>> design/lzss4k_pkg.sv
// shared types and constants for the lzss 4k decoder core
// no dependencies
package lzss4k_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int CFG_W = 32;
  localparam int LEN_BIAS = 3;
  localparam int GROUP_TOKENS = 8;

  typedef enum logic {
    CFG_IN_LIMIT  = 1'b0,
    CFG_OUT_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
  } emit_t;

endpackage

>>> design/lzss4k_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module lzss4k_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/lzss4k_ctrl.sv
// token sequencer and byte copy engine of the lzss 4k decoder
// depends on lzss4k_pkg and lzss_decoder_4k_core_macros.svh
`include "lzss_decoder_4k_core_macros.svh"

module lzss4k_ctrl #(
  parameter int WINDOW_DEPTH = lzss4k_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic [lzss4k_pkg::CFG_W-1:0]    in_limit,
  input  logic [lzss4k_pkg::CFG_W-1:0]    out_limit,
  input  logic                            slot_free,
  output lzss4k_pkg::emit_t               emit,
  output logic                            ram_we,
  output logic [$clog2(WINDOW_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(WINDOW_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                      ram_rdata
);

  import lzss4k_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  typedef enum logic [1:0] {
    S_IN,
    S_LIT,
    S_COPY
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH
  } phase_t;

  state_t           state;
  phase_t           phase;
  logic [7:0]       flag_bits;
  logic [3:0]       bits_left;
  logic [7:0]       match_low;
  logic [CFG_W-1:0] in_count;
  logic [CFG_W-1:0] out_count;
  logic             finished;
  logic [AW-1:0]    write_pos;
  logic             full;
  logic [7:0]       lit_byte;
  logic [AW-1:0]    src;
  logic [AW-1:0]    match_dist;
  logic [4:0]       remaining;
  logic             rd_ok;
  logic             fwd;
  logic [7:0]       fwd_byte;

  logic             in_acc;
  logic             emit_go;
  logic             is_last;
  logic [7:0]       emit_byte;
  logic [CFG_W-1:0] in_count_next;
  logic [CFG_W-1:0] out_count_next;
  logic [AW-1:0]    write_pos_next;
  logic             full_next;
  logic [3:0]       bits_left_next;
  logic             fin_tok;
  logic [AW-1:0]    dist_new;
  logic [AW-1:0]    src_start;
  logic [AW-1:0]    src_next;
  logic             start_ok;
  logic             next_ok;
  logic             copy_more;

  assign in_stall  = (state != S_IN);
  assign in_acc    = in_valid && !in_stall;
  assign emit_go   = slot_free && (state == S_LIT || state == S_COPY);
  assign is_last   = (state == S_LIT) || (remaining == 5'd1);
  assign copy_more = emit_go && (state == S_COPY) && !is_last;

  always_comb begin
    if (state == S_LIT) begin
      emit_byte = lit_byte;
    end else if (fwd) begin
      emit_byte = fwd_byte;
    end else if (rd_ok) begin
      emit_byte = ram_rdata;
    end else begin
      emit_byte = '0;
    end
  end

  assign in_count_next  = (in_count == '1) ? in_count : in_count + 1'b1;
  assign out_count_next = (out_count == '1) ? out_count : out_count + 1'b1;
  assign write_pos_next = write_pos + 1'b1;
  assign full_next      = full || (write_pos == '1);
  assign bits_left_next = bits_left - 1'b1;
  assign fin_tok        = (in_count >= in_limit) ||
                          (bits_left_next == '0 && out_count_next >= out_limit);

  assign dist_new  = AW'({data_byte[7:4], match_low} + 12'd1);
  assign src_start = write_pos - dist_new;
  assign src_next  = src + 1'b1;
  assign start_ok  = full || (src_start < write_pos);
  assign next_ok   = full_next || (src_next < write_pos_next);

  assign emit.valid = emit_go;
  assign emit.data  = emit_byte;
  assign emit.last  = is_last;
  assign emit.done  = is_last && fin_tok;

  assign ram_we    = emit_go;
  assign ram_waddr = write_pos;
  assign ram_wdata = emit_byte;
  assign ram_re    = (in_acc && !finished && phase == PH_MATCH) || copy_more;
  assign ram_raddr = (state == S_COPY) ? src_next : src_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      phase     <= PH_FLAG;
      flag_bits <= '0;
      bits_left <= '0;
      match_low <= '0;
      in_count  <= '0;
      out_count <= '0;
      finished  <= 1'b0;
      write_pos <= '0;
      full      <= 1'b0;
      remaining <= '0;
      rd_ok     <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      if (in_acc && !finished) begin
        case (phase)
          PH_FLAG: begin
            if (in_count >= in_limit || out_count >= out_limit) begin
              finished <= 1'b1;
            end else begin
              in_count  <= in_count_next;
              flag_bits <= data_byte;
              bits_left <= 4'(GROUP_TOKENS);
              phase     <= PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            in_count <= in_count_next;
            if (flag_bits[0]) begin
              lit_byte <= data_byte;
              state    <= S_LIT;
            end else begin
              match_low <= data_byte;
              phase     <= PH_MATCH;
            end
          end
          PH_MATCH: begin
            in_count   <= in_count_next;
            match_dist <= dist_new;
            src        <= src_start;
            remaining  <= 5'(data_byte[3:0]) + 5'(LEN_BIAS);
            rd_ok      <= start_ok;
            fwd        <= 1'b0;
            state      <= S_COPY;
          end
          default: begin
            phase <= PH_FLAG;
          end
        endcase
      end
      if (emit_go) begin
        write_pos <= write_pos_next;
        full      <= full_next;
        out_count <= out_count_next;
        if (copy_more) begin
          remaining <= remaining - 1'b1;
          src       <= src_next;
          rd_ok     <= next_ok;
          fwd       <= (match_dist == AW'(1));
          fwd_byte  <= emit_byte;
        end
        if (is_last) begin
          state     <= S_IN;
          flag_bits <= flag_bits >> 1;
          bits_left <= bits_left_next;
          phase     <= (bits_left_next == '0) ? PH_FLAG : PH_TOKEN;
          finished  <= fin_tok;
        end
      end
    end
  end

  `LZ4K_ASSERT_IMP(a_copy_count, state == S_COPY, remaining != '0)
  `LZ4K_ASSERT_IMP(a_done_on_last, emit.valid && emit.done, emit.last)
  `LZ4K_ASSERT_NEXT(a_finished_sticks, finished, finished)
  `LZ4K_ASSERT_NEXT(a_no_work_after_end, finished && state == S_IN, state == S_IN)
  `LZ4K_ASSERT_IMP(a_busy_in_token, state != S_IN, phase != PH_FLAG || bits_left != '0)

endmodule

>>> design/lzss_decoder_4k_core.sv
// lzss decoder with a 4096-byte history window: usage
// in channel: one compressed byte per beat (in_valid, in_stall, data_byte).
// out channel: one decompressed byte per beat with run_last on the final
// byte caused by an input beat and decode_done when decoding ended there.
// config: cfg_we writes cfg_data into in_limit (index 0) or out_limit
// (index 1); write only while the block is idle.
// flow: a flag byte or the first byte of a match is taken while in_stall stays low.
// a literal is held in lit_byte and then in the output register.
// a match of n bytes (3 to 18) sends one byte per cycle while the receiver
// does not stall; the first passes the ram's registered read data and then
// the output register, paced by the single history read and write port of the ram.
// reset: pointers, counters and limits clear at once; history entries not
// yet written read as zero, so there is no clearing pass.
// when the receiver stalls, the result register holds and the copy
// engine waits; in_stall stays high until the current token is done.
// once decoding ends every later beat is taken and dropped.
// depends on lzss4k_pkg, lzss4k_ram and lzss4k_ctrl
module lzss_decoder_4k_core #(
  parameter int WINDOW_DEPTH = lzss4k_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         run_last,
  output logic                         decode_done,
  input  logic                         cfg_we,
  input  lzss4k_pkg::cfg_idx_t         cfg_index,
  input  logic [lzss4k_pkg::CFG_W-1:0] cfg_data
);

  import lzss4k_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [CFG_W-1:0] in_limit;
  logic [CFG_W-1:0] out_limit;
  emit_t            emit;
  logic             slot_free;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_limit  <= '0;
      out_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IN_LIMIT:  in_limit  <= cfg_data;
        CFG_OUT_LIMIT: out_limit <= cfg_data;
        default:       in_limit  <= in_limit;
      endcase
    end
  end

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid   <= 1'b1;
      out_byte    <= emit.data;
      run_last    <= emit.last;
      decode_done <= emit.done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  lzss4k_ctrl #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .in_limit  (in_limit),
    .out_limit (out_limit),
    .slot_free (slot_free),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lzss4k_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
